// ===== src/pls_pkg.sv =====
// Shared codes, types and defaults for the positional list store.
`timescale 1ns / 1ps
package pls_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int DATA_W = 32;
   localparam int OP_W = 3;
   localparam int POS_W = 7;
   localparam int STATUS_W = 2;

   // Operation codes carried by req_operation.
   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
   localparam logic [OP_W-1:0] OP_READ_OUT  = 3'd6;

   // Status codes carried by rsp_status.
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   // What every cell of the chain does in a cycle.
   localparam logic [1:0] MODE_HOLD   = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;
   localparam logic [1:0] MODE_ROTATE = 2'd3;

   typedef struct packed {
      logic [1:0]               mode;
      logic signed [DATA_W-1:0] item;
   } cell_ctrl_type;

endpackage

// ===== src/positional_list_store.sv =====
// Top level of the positional list store: sequencer plus a chain of storage cells.
`timescale 1ns / 1ps
// The store keeps an ordered list of up to CAPACITY signed 32-bit values in a row
// of cells, front entry in cell 0. A transaction is taken at a rising edge where
// start is high and busy is low. Inserts and deletes move every cell at once, so
// busy stays low and a new transaction can be taken in each cycle; the status
// result is registered and appears in the next cycle with rsp_last set. A
// read-out emits the front value in the cycle after acceptance and then one value
// per cycle by rotating the chain toward cell 0, so a list of N entries holds busy
// high while the chain rotates and returns N results; reading an empty
// list gives a single empty status. Each result is valid only in the cycle that
// rsp_strobe is high and cannot be held off, so the receiver must take it then.
// Operation code 7 is accepted and produces no result.
module positional_list_store #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pls_pkg::OP_W-1:0]            req_operation,
   input  logic signed [pls_pkg::DATA_W-1:0]   req_item,
   input  logic [pls_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_strobe,
   output logic [pls_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [pls_pkg::DATA_W-1:0]   rsp_value,
   output logic                                rsp_last
);
   import pls_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   cell_ctrl_type            cell_ctrl;
   logic [IDX_W-1:0]         cell_idx;
   logic [CNT_W-1:0]         cell_count;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];

   // The sequencer owns the entry count and the result registers; the cells see
   // which way to move in the current cycle, plus the index, item and entry count.
   pls_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_item      (req_item),
      .req_position  (req_position),
      .head_value    (cell_value[0]),
      .cell_ctrl     (cell_ctrl),
      .cell_idx      (cell_idx),
      .cell_count    (cell_count),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_value     (rsp_value),
      .rsp_last      (rsp_last)
   );

   // Each cell reads its lower neighbor on insert and its upper neighbor on
   // delete or rotate. The lower end is tied to req_item, which cell 0 never selects;
   // the upper end is tied to the last cell's own value, which a delete leaves in place.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = req_item;
      end else begin : g_inner_left
         assign left_value = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[g];
      end else begin : g_inner_right
         assign right_value = cell_value[g+1];
      end

      pls_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (g),
         .IDX_W    (IDX_W),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .idx         (cell_idx),
         .count       (cell_count),
         .left_value  (left_value),
         .right_value (right_value),
         .head_value  (cell_value[0]),
         .value       (cell_value[g])
      );
   end

endmodule

// ===== src/pls_cell.sv =====
// One storage cell of the list chain: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps
module pls_cell #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEFAULT,
   parameter int INDEX = 0,
   parameter int IDX_W = $clog2(CAPACITY),
   parameter int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  pls_pkg::cell_ctrl_type            ctrl,
   input  logic [IDX_W-1:0]                  idx,
   input  logic [CNT_W-1:0]                  count,
   input  logic signed [pls_pkg::DATA_W-1:0] left_value,
   input  logic signed [pls_pkg::DATA_W-1:0] right_value,
   input  logic signed [pls_pkg::DATA_W-1:0] head_value,
   output logic signed [pls_pkg::DATA_W-1:0] value
);
   import pls_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(INDEX + 1);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.mode)
         MODE_INSERT: begin
            if (MY_IDX > idx) begin
               value_in = left_value;
            end else if (MY_IDX == idx) begin
               value_in = ctrl.item;
            end
         end
         MODE_REMOVE: begin
            if (MY_IDX >= idx) begin
               value_in = right_value;
            end
         end
         MODE_ROTATE: begin
            // The tail cell wraps around to the head so the list is restored
            // after a full pass.
            if (MY_NEXT == count) begin
               value_in = head_value;
            end else if (MY_NEXT < count) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== src/pls_ctrl.sv =====
// Sequencer of the list store: decodes operations, keeps the count, drives the results.
`timescale 1ns / 1ps
module pls_ctrl #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEFAULT,
   parameter int IDX_W = $clog2(CAPACITY),
   parameter int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pls_pkg::OP_W-1:0]            req_operation,
   input  logic signed [pls_pkg::DATA_W-1:0]   req_item,
   input  logic [pls_pkg::POS_W-1:0]           req_position,
   input  logic signed [pls_pkg::DATA_W-1:0]   head_value,
   output pls_pkg::cell_ctrl_type              cell_ctrl,
   output logic [IDX_W-1:0]                    cell_idx,
   output logic [CNT_W-1:0]                    cell_count,
   output logic                                rsp_strobe,
   output logic [pls_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [pls_pkg::DATA_W-1:0]   rsp_value,
   output logic                                rsp_last
);
   import pls_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;
   localparam int CMP_W = POS_W + 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_COUNT = CNT_W'(1);

   logic                     state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic                     strobe_ff, strobe_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     last_ff, last_in;

   logic             accept;
   logic             full;
   logic             empty;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [POS_W-1:0] pos_m1;
   logic [CNT_W-1:0] cnt_m1;

   assign busy    = (state_ff == S_READ);
   assign accept  = start && !busy;
   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign pos_m1  = req_position - POS_W'(1);
   assign cnt_m1  = count_ff - ONE_COUNT;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      remain_in      = remain_ff;
      strobe_in      = 1'b0;
      status_in      = ST_OK;
      value_in       = '0;
      last_in        = 1'b1;
      cell_ctrl.mode = MODE_HOLD;
      cell_ctrl.item = req_item;
      cell_idx       = '0;

      if (state_ff == S_READ) begin
         strobe_in      = 1'b1;
         value_in       = head_value;
         last_in        = (remain_ff == ONE_COUNT);
         cell_ctrl.mode = MODE_ROTATE;
         remain_in      = remain_ff - ONE_COUNT;
         if (remain_ff == ONE_COUNT) begin
            state_in = S_IDLE;
         end
      end else if (accept) begin
         unique case (req_operation)
            OP_INS_FRONT: begin
               strobe_in = 1'b1;
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  cell_ctrl.mode = MODE_INSERT;
                  count_in       = count_ff + ONE_COUNT;
               end
            end
            OP_INS_BACK: begin
               strobe_in = 1'b1;
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  cell_ctrl.mode = MODE_INSERT;
                  cell_idx       = IDX_W'(count_ff);
                  count_in       = count_ff + ONE_COUNT;
               end
            end
            OP_INS_POS: begin
               strobe_in = 1'b1;
               if (full) begin
                  status_in = ST_FULL;
               end else if (req_position == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                  status_in = ST_BADPOS;
               end else begin
                  cell_ctrl.mode = MODE_INSERT;
                  cell_idx       = IDX_W'(pos_m1);
                  count_in       = count_ff + ONE_COUNT;
               end
            end
            OP_DEL_FRONT: begin
               strobe_in = 1'b1;
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  cell_ctrl.mode = MODE_REMOVE;
                  count_in       = cnt_m1;
               end
            end
            OP_DEL_BACK: begin
               strobe_in = 1'b1;
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  cell_ctrl.mode = MODE_REMOVE;
                  cell_idx       = IDX_W'(cnt_m1);
                  count_in       = cnt_m1;
               end
            end
            OP_DEL_POS: begin
               strobe_in = 1'b1;
               if (empty) begin
                  status_in = ST_EMPTY;
               end else if (req_position == '0 || pos_ext > cnt_ext) begin
                  status_in = ST_BADPOS;
               end else begin
                  cell_ctrl.mode = MODE_REMOVE;
                  cell_idx       = IDX_W'(pos_m1);
                  count_in       = cnt_m1;
               end
            end
            OP_READ_OUT: begin
               strobe_in = 1'b1;
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  // The front value is registered now; the rest follow one a cycle.
                  value_in       = head_value;
                  last_in        = (count_ff == ONE_COUNT);
                  cell_ctrl.mode = MODE_ROTATE;
                  if (count_ff != ONE_COUNT) begin
                     state_in  = S_READ;
                     remain_in = cnt_m1;
                  end
               end
            end
            default: begin
               strobe_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         remain_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   assign cell_count = count_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_value  = value_ff;
   assign rsp_last   = last_ff;

endmodule
